FILE: rtl/core/knob_pulse_lockout_qualifier_macros.svh
// Assertion macros shared by the knob pulse lockout qualifier RTL.
`ifndef KNOB_PULSE_LOCKOUT_QUALIFIER_MACROS_SVH
`define KNOB_PULSE_LOCKOUT_QUALIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define KPLQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kplq assertion failed");
`define KPLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kplq assertion failed");
`else
`define KPLQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define KPLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/kplq_pkg.sv
// Types and constants shared by the knob pulse lockout qualifier.
`default_nettype none

package kplq_pkg;

    typedef enum logic [1:0] {
        REQ_LEFT  = 2'd0,
        REQ_RIGHT = 2'd1,
        REQ_TAKE  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        V_CW     = 3'd0,
        V_CCW    = 3'd1,
        V_SAME   = 3'd2,
        V_OPP    = 3'd3,
        V_GLITCH = 3'd4,
        V_NONE   = 3'd5
    } verdict_t;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAME_LOCKOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPP_LOCKOUT  = 2'd1;

    localparam logic [31:0] SAME_LOCKOUT_RESET = 32'd80000;
    localparam logic [31:0] OPP_LOCKOUT_RESET  = 32'd150000;

    // Elapsed times are capped at 65535000 us, which fits in 26 bits.
    localparam int ELAPSED_W = 26;
    localparam logic [ELAPSED_W-1:0] DT_CAP_US = 26'd65535000;

    // x / 1000 = ((x >> 3) * ceil(2^30 / 125)) >> 30 for x below 2^26.
    localparam int MS_PRE_SHIFT = 3;
    localparam int MS_RECIP_W   = 24;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 24'd8589935;
    localparam int MS_SHIFT     = 30;
    localparam int MS_W         = 16;

    localparam int VERDICT_KINDS = 5;
    localparam int VERDICT_IDX_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        req_t                 req;
        logic                 left_level;
        logic                 right_level;
        verdict_t             verdict;
        logic [ELAPSED_W-1:0] e_same;
        logic [ELAPSED_W-1:0] e_opp;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/kplq_if.sv
// Handshake interfaces for the pulse, result and configuration channels.
`default_nettype none

interface kplq_pulse_if #(parameter int TIME_WIDTH = 48);
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [TIME_WIDTH-1:0] now_us;
    logic                  left_level;
    logic                  right_level;

    modport source (output valid, output req_type, output now_us, output left_level,
                     output right_level, input ready);
    modport sink (input valid, input req_type, input now_us, input left_level,
                  input right_level, output ready);
endinterface

interface kplq_result_if #(parameter int COUNT_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic                   pin_is_right;
    logic                   left_seen;
    logic                   right_seen;
    logic [2:0]             verdict;
    logic [15:0]            since_same_ms;
    logic [15:0]            since_opposite_ms;
    logic signed [31:0]     position_total;
    logic signed [31:0]     pending_delta;
    logic [COUNT_WIDTH-1:0] verdict_count;

    modport source (output valid, output pin_is_right, output left_seen, output right_seen,
                    output verdict, output since_same_ms, output since_opposite_ms,
                    output position_total, output pending_delta, output verdict_count,
                    input ready);
    modport sink (input valid, input pin_is_right, input left_seen, input right_seen,
                  input verdict, input since_same_ms, input since_opposite_ms,
                  input position_total, input pending_delta, input verdict_count,
                  output ready);
endinterface

interface kplq_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [kplq_pkg::CFG_INDEX_W-1:0]    index;
    logic [31:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kplq_front.sv
// Front end: takes pulse words, holds the lockout registers and accept times, classifies.
`default_nettype none

module kplq_front #(
    parameter int TIME_WIDTH = 48
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    kplq_pulse_if.sink          pulse,
    kplq_cfg_if.sink            cfg,
    input  wire logic           queue_ready,
    output logic                push,
    output kplq_pkg::entry_t    push_entry
);

    logic [31:0]           same_lock_reg;
    logic [31:0]           same_lock_next;
    logic [31:0]           opp_lock_reg;
    logic [31:0]           opp_lock_next;
    logic [TIME_WIDTH-1:0] left_time_reg;
    logic [TIME_WIDTH-1:0] left_time_next;
    logic [TIME_WIDTH-1:0] right_time_reg;
    logic [TIME_WIDTH-1:0] right_time_next;

    kplq_pkg::req_t        req;
    logic                  is_right;
    logic                  own_level;
    logic [TIME_WIDTH-1:0] own_time;
    logic [TIME_WIDTH-1:0] other_time;
    logic [TIME_WIDTH-1:0] e_same;
    logic [TIME_WIDTH-1:0] e_opp;
    logic [kplq_pkg::ELAPSED_W-1:0] e_same_cap;
    logic [kplq_pkg::ELAPSED_W-1:0] e_opp_cap;
    kplq_pkg::verdict_t    verdict;
    logic                  is_edge;

    assign pulse.ready = queue_ready;
    assign cfg.ready   = 1'b1;
    assign push        = pulse.valid && queue_ready;

    assign req        = kplq_pkg::req_t'(pulse.req_type);
    assign is_right   = (req == kplq_pkg::REQ_RIGHT);
    assign own_level  = is_right ? pulse.right_level : pulse.left_level;
    assign own_time   = is_right ? right_time_reg : left_time_reg;
    assign other_time = is_right ? left_time_reg : right_time_reg;
    assign e_same     = (pulse.now_us >= own_time) ? (pulse.now_us - own_time) : '0;
    assign e_opp      = (pulse.now_us >= other_time) ? (pulse.now_us - other_time) : '0;
    assign e_same_cap = (e_same > TIME_WIDTH'(kplq_pkg::DT_CAP_US)) ? kplq_pkg::DT_CAP_US
                      : e_same[kplq_pkg::ELAPSED_W-1:0];
    assign e_opp_cap  = (e_opp > TIME_WIDTH'(kplq_pkg::DT_CAP_US)) ? kplq_pkg::DT_CAP_US
                      : e_opp[kplq_pkg::ELAPSED_W-1:0];

    always_comb
    begin
        is_edge = 1'b0;
        verdict = kplq_pkg::V_NONE;
        unique case (req) inside
            kplq_pkg::REQ_LEFT, kplq_pkg::REQ_RIGHT:
            begin
                is_edge = 1'b1;
                if (own_level)
                begin
                    verdict = kplq_pkg::V_GLITCH;
                end
                else if (e_opp < TIME_WIDTH'(opp_lock_reg))
                begin
                    verdict = kplq_pkg::V_OPP;
                end
                else if (e_same < TIME_WIDTH'(same_lock_reg))
                begin
                    verdict = kplq_pkg::V_SAME;
                end
                else
                begin
                    verdict = is_right ? kplq_pkg::V_CW : kplq_pkg::V_CCW;
                end
            end
            default:
            begin
                is_edge = 1'b0;
                verdict = kplq_pkg::V_NONE;
            end
        endcase
    end

    always_comb
    begin
        push_entry.req         = req;
        push_entry.left_level  = pulse.left_level;
        push_entry.right_level = pulse.right_level;
        push_entry.verdict     = verdict;
        push_entry.e_same      = is_edge ? e_same_cap : '0;
        push_entry.e_opp       = is_edge ? e_opp_cap : '0;
    end

    always_comb
    begin
        left_time_next  = left_time_reg;
        right_time_next = right_time_reg;
        if (push && (verdict == kplq_pkg::V_CW))
        begin
            right_time_next = pulse.now_us;
        end
        if (push && (verdict == kplq_pkg::V_CCW))
        begin
            left_time_next = pulse.now_us;
        end
    end

    always_comb
    begin
        same_lock_next = same_lock_reg;
        opp_lock_next  = opp_lock_reg;
        if (cfg.valid)
        begin
            if (cfg.index == kplq_pkg::CFG_SAME_LOCKOUT)
            begin
                same_lock_next = cfg.data;
            end
            if (cfg.index == kplq_pkg::CFG_OPP_LOCKOUT)
            begin
                opp_lock_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_lock_reg  <= kplq_pkg::SAME_LOCKOUT_RESET;
            opp_lock_reg   <= kplq_pkg::OPP_LOCKOUT_RESET;
            left_time_reg  <= '0;
            right_time_reg <= '0;
        end
        else
        begin
            same_lock_reg  <= same_lock_next;
            opp_lock_reg   <= opp_lock_next;
            left_time_reg  <= left_time_next;
            right_time_reg <= right_time_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/kplq_queue.sv
// Two-entry queue that decouples the classifier from the statistics stage.
`default_nettype none

`include "knob_pulse_lockout_qualifier_macros.svh"

module kplq_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kplq_pkg::entry_t  push_entry,
    output logic                   push_ready,
    input  wire logic              pop,
    output kplq_pkg::entry_t       pop_entry,
    output logic                   pop_valid
);

    kplq_pkg::entry_t                    mem_reg [kplq_pkg::QUEUE_DEPTH];
    logic [kplq_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [kplq_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [kplq_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [kplq_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [kplq_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [kplq_pkg::QUEUE_CNT_W-1:0]    count_next;

    assign push_ready = (count_reg < kplq_pkg::QUEUE_CNT_W'(kplq_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `KPLQ_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, count_reg < kplq_pkg::QUEUE_CNT_W'(kplq_pkg::QUEUE_DEPTH))
    `KPLQ_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, count_reg != '0)

endmodule

`default_nettype wire

FILE: rtl/core/kplq_back.sv
// Back end: millisecond conversion, counters, delta and total, and the output register.
`default_nettype none

`include "knob_pulse_lockout_qualifier_macros.svh"

module kplq_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    input  wire kplq_pkg::entry_t  pop_entry,
    output logic                   pop,
    kplq_result_if.source          result
);

    localparam int PROD_W = kplq_pkg::ELAPSED_W - kplq_pkg::MS_PRE_SHIFT + kplq_pkg::MS_RECIP_W;

    logic [COUNT_WIDTH-1:0] counter_reg [kplq_pkg::VERDICT_KINDS];
    logic [COUNT_WIDTH-1:0] counter_next [kplq_pkg::VERDICT_KINDS];
    logic signed [31:0]     delta_reg;
    logic signed [31:0]     delta_next;
    logic signed [31:0]     total_reg;
    logic signed [31:0]     total_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   pin_is_right_reg;
    logic                   left_seen_reg;
    logic                   right_seen_reg;
    logic [2:0]             verdict_reg;
    logic [15:0]            since_same_reg;
    logic [15:0]            since_opp_reg;
    logic signed [31:0]     pend_reg;
    logic signed [31:0]     pend_next;
    logic [COUNT_WIDTH-1:0] vcount_reg;
    logic [COUNT_WIDTH-1:0] vcount_next;

    logic [kplq_pkg::VERDICT_IDX_W-1:0] idx;
    logic [COUNT_WIDTH-1:0]             cnt_inc;
    logic [PROD_W-1:0]                  prod_same;
    logic [PROD_W-1:0]                  prod_opp;

    assign pop  = pop_valid && (!out_valid_reg || result.ready);
    assign idx  = pop_entry.verdict;

    assign prod_same = PROD_W'(pop_entry.e_same[kplq_pkg::ELAPSED_W-1:kplq_pkg::MS_PRE_SHIFT])
                     * PROD_W'(kplq_pkg::MS_RECIP);
    assign prod_opp  = PROD_W'(pop_entry.e_opp[kplq_pkg::ELAPSED_W-1:kplq_pkg::MS_PRE_SHIFT])
                     * PROD_W'(kplq_pkg::MS_RECIP);

    always_comb
    begin
        counter_next   = counter_reg;
        delta_next     = delta_reg;
        total_next     = total_reg;
        pend_next      = delta_reg;
        vcount_next    = '0;
        cnt_inc        = counter_reg[idx] + 1'b1;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            unique case (pop_entry.req) inside
                kplq_pkg::REQ_LEFT, kplq_pkg::REQ_RIGHT:
                begin
                    counter_next[idx] = cnt_inc;
                    vcount_next       = cnt_inc;
                    if (pop_entry.verdict == kplq_pkg::V_CW)
                    begin
                        delta_next = delta_reg + 32'sd1;
                        total_next = total_reg + 32'sd1;
                    end
                    else if (pop_entry.verdict == kplq_pkg::V_CCW)
                    begin
                        delta_next = delta_reg - 32'sd1;
                        total_next = total_reg - 32'sd1;
                    end
                    pend_next = delta_next;
                end
                kplq_pkg::REQ_TAKE:
                begin
                    delta_next = '0;
                end
                kplq_pkg::REQ_CLEAR:
                begin
                    delta_next = '0;
                    total_next = '0;
                    for (int i = 0; i < kplq_pkg::VERDICT_KINDS; i++)
                    begin
                        counter_next[i] = '0;
                    end
                end
                default:
                begin
                    delta_next = delta_reg;
                end
            endcase
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pin_is_right_reg <= (pop_entry.req == kplq_pkg::REQ_RIGHT);
            left_seen_reg    <= pop_entry.left_level;
            right_seen_reg   <= pop_entry.right_level;
            verdict_reg      <= pop_entry.verdict;
            since_same_reg   <= prod_same[kplq_pkg::MS_SHIFT +: kplq_pkg::MS_W];
            since_opp_reg    <= prod_opp[kplq_pkg::MS_SHIFT +: kplq_pkg::MS_W];
            pend_reg         <= pend_next;
            vcount_reg       <= vcount_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kplq_pkg::VERDICT_KINDS; i++)
            begin
                counter_reg[i] <= '0;
            end
            delta_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            delta_reg     <= delta_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.pin_is_right      = pin_is_right_reg;
    assign result.left_seen         = left_seen_reg;
    assign result.right_seen        = right_seen_reg;
    assign result.verdict           = verdict_reg;
    assign result.since_same_ms     = since_same_reg;
    assign result.since_opposite_ms = since_opp_reg;
    assign result.position_total    = total_reg;
    assign result.pending_delta     = pend_reg;
    assign result.verdict_count     = vcount_reg;

    `KPLQ_ASSERT_NEXT(a_pop_loads, clk, rst_n, pop, out_valid_reg)
    `KPLQ_ASSERT_NEXT(a_clear_zeroes, clk, rst_n, pop && (pop_entry.req == kplq_pkg::REQ_CLEAR), (total_reg == '0) && (delta_reg == '0) && (result.verdict_count == '0))
    `KPLQ_ASSERT_IMPLIES(a_none_for_cmds, clk, rst_n, pop && ((pop_entry.req == kplq_pkg::REQ_TAKE) || (pop_entry.req == kplq_pkg::REQ_CLEAR)), pop_entry.verdict == kplq_pkg::V_NONE)

endmodule

`default_nettype wire

FILE: rtl/core/knob_pulse_lockout_qualifier.sv
// A taken pulse word is stored in the queue, then its result word in the output register.
// Throughput: one word per cycle while the queue has room; accept times update on intake.
// A two-entry queue lets intake continue while a finished word waits to be taken.
// Reset clears accept times, delta, total and counters and loads the lockouts with 80000
// and 150000 us; the block can take words as soon as reset is released.
`default_nettype none

module knob_pulse_lockout_qualifier #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    kplq_pulse_if.sink     pulse,
    kplq_result_if.source  result,
    kplq_cfg_if.sink       cfg
);

    logic             push;
    logic             push_ready;
    logic             pop;
    logic             pop_valid;
    kplq_pkg::entry_t push_entry;
    kplq_pkg::entry_t pop_entry;

    kplq_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse       (pulse),
        .cfg         (cfg),
        .queue_ready (push_ready),
        .push        (push),
        .push_entry  (push_entry)
    );

    kplq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid)
    );

    kplq_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the knob pulse lockout qualifier: directed and random words.
`default_nettype none

module testbench;

    localparam int          TIME_W      = 48;
    localparam int          CNT_W       = 32;
    localparam logic [kplq_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [kplq_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [TIME_W-1:0] STAMP_TOP   = '1;
    localparam logic [TIME_W-1:0] MS_CAP_US   = 48'd65535000;
    localparam logic [TIME_W-1:0] US_PER_MS   = 48'd1000;
    localparam logic [31:0]       WINDOW_MAX  = 32'hFFFF_FFFF;
    localparam longint            RUN_LIMIT   = 64'd4_000_000;

    typedef struct {
        logic               pin_is_right;
        logic               left_seen;
        logic               right_seen;
        kplq_pkg::verdict_t verdict;
        logic [15:0]        since_same_ms;
        logic [15:0]        since_opposite_ms;
        logic signed [31:0] position_total;
        logic signed [31:0] pending_delta;
        logic [CNT_W-1:0]   verdict_count;
    } knob_word_t;

    logic clk;
    logic rst_n;

    kplq_pulse_if  #(.TIME_WIDTH(TIME_W)) pulse_ch ();
    kplq_result_if #(.COUNT_WIDTH(CNT_W)) result_ch ();
    kplq_cfg_if                           cfg_ch ();

    knob_pulse_lockout_qualifier #(
        .TIME_WIDTH  (TIME_W),
        .COUNT_WIDTH (CNT_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pulse  (pulse_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the block's state and lockout windows.
    logic [31:0]        same_window_us;
    logic [31:0]        opp_window_us;
    logic [TIME_W-1:0]  left_accept_us;
    logic [TIME_W-1:0]  right_accept_us;
    logic [31:0]        step_delta;
    logic [31:0]        step_total;
    logic [CNT_W-1:0]   verdict_counts [kplq_pkg::VERDICT_KINDS];

    knob_word_t         expected_words [$];
    logic [TIME_W-1:0]  stamp_us;
    bit                 idling_enabled;
    int                 mismatches;
    int                 words_sent;
    int                 words_checked;
    int                 verdict_tally [6];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic logic [TIME_W-1:0] elapsed_us(logic [TIME_W-1:0] now,
                                                      logic [TIME_W-1:0] since);
        return (now >= since) ? now - since : '0;
    endfunction

    function automatic logic [15:0] to_ms(logic [TIME_W-1:0] span);
        logic [TIME_W-1:0] ms;
        ms = span / US_PER_MS;
        return (span > MS_CAP_US) ? 16'hFFFF : ms[15:0];
    endfunction

    function automatic knob_word_t qualify_pulse(kplq_pkg::req_t req, logic [TIME_W-1:0] now,
                                                 logic lvl_l, logic lvl_r);
        knob_word_t        w;
        logic              right;
        logic              own_lvl;
        logic [TIME_W-1:0] e_same;
        logic [TIME_W-1:0] e_opp;
        w.pin_is_right      = 1'b0;
        w.left_seen         = lvl_l;
        w.right_seen        = lvl_r;
        w.verdict           = kplq_pkg::V_NONE;
        w.since_same_ms     = '0;
        w.since_opposite_ms = '0;
        w.verdict_count     = '0;
        if (req == kplq_pkg::REQ_LEFT || req == kplq_pkg::REQ_RIGHT)
        begin
            right   = (req == kplq_pkg::REQ_RIGHT);
            own_lvl = right ? lvl_r : lvl_l;
            e_same  = elapsed_us(now, right ? right_accept_us : left_accept_us);
            e_opp   = elapsed_us(now, right ? left_accept_us : right_accept_us);
            w.pin_is_right      = right;
            w.since_same_ms     = to_ms(e_same);
            w.since_opposite_ms = to_ms(e_opp);
            if (own_lvl)
                w.verdict = kplq_pkg::V_GLITCH;
            else if (e_opp < {16'd0, opp_window_us})
                w.verdict = kplq_pkg::V_OPP;
            else if (e_same < {16'd0, same_window_us})
                w.verdict = kplq_pkg::V_SAME;
            else if (right)
            begin
                right_accept_us = now;
                step_delta      = step_delta + 32'd1;
                step_total      = step_total + 32'd1;
                w.verdict       = kplq_pkg::V_CW;
            end
            else
            begin
                left_accept_us = now;
                step_delta     = step_delta - 32'd1;
                step_total     = step_total - 32'd1;
                w.verdict      = kplq_pkg::V_CCW;
            end
            verdict_counts[w.verdict] = verdict_counts[w.verdict] + 1'b1;
            w.verdict_count = verdict_counts[w.verdict];
            w.pending_delta = step_delta;
        end
        else
        begin
            w.pending_delta = step_delta;
            step_delta      = '0;
            if (req == kplq_pkg::REQ_CLEAR)
            begin
                step_total = '0;
                foreach (verdict_counts[i])
                    verdict_counts[i] = '0;
            end
        end
        w.position_total = step_total;
        return w;
    endfunction

    task automatic send_word(kplq_pkg::req_t req, logic [TIME_W-1:0] now, logic lvl_l,
                             logic lvl_r);
        if (idling_enabled && $urandom_range(0, 3) == 0)
        begin
            pulse_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        pulse_ch.valid       <= 1'b1;
        pulse_ch.req_type    <= req;
        pulse_ch.now_us      <= now;
        pulse_ch.left_level  <= lvl_l;
        pulse_ch.right_level <= lvl_r;
        do @(posedge clk); while (!pulse_ch.ready);
        expected_words.push_back(qualify_pulse(req, now, lvl_l, lvl_r));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        pulse_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [kplq_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == kplq_pkg::CFG_SAME_LOCKOUT)
            same_window_us = value;
        else if (idx == kplq_pkg::CFG_OPP_LOCKOUT)
            opp_window_us = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic advance_stamp();
        logic [63:0] span;
        logic [63:0] gap;
        int unsigned pick;
        span = {32'd0, (same_window_us > opp_window_us) ? same_window_us : opp_window_us};
        span = span + span / 2 + 64'd1;
        pick = $urandom_range(0, 39);
        gap  = {$urandom, $urandom};
        if (pick == 0)
            stamp_us = stamp_us + 48'(gap[39:0]);
        else if (pick == 1)
            stamp_us = stamp_us - 48'($urandom_range(0, 100000));
        else if (pick < 6)
            stamp_us = stamp_us;
        else
            stamp_us = stamp_us + 48'(gap % span);
    endtask

    task automatic run_random(int count);
        kplq_pkg::req_t req;
        int unsigned    pick;
        logic           lvl_l;
        logic           lvl_r;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                req = kplq_pkg::REQ_LEFT;
            else if (pick < 16)
                req = kplq_pkg::REQ_RIGHT;
            else if (pick < 19)
                req = kplq_pkg::REQ_TAKE;
            else
                req = kplq_pkg::REQ_CLEAR;
            lvl_l = 1'($urandom_range(0, 1));
            lvl_r = 1'($urandom_range(0, 1));
            if (req == kplq_pkg::REQ_LEFT)
                lvl_l = ($urandom_range(0, 6) == 0);
            else if (req == kplq_pkg::REQ_RIGHT)
                lvl_r = ($urandom_range(0, 6) == 0);
            advance_stamp();
            send_word(req, stamp_us, lvl_l, lvl_r);
            if (idling_enabled && $urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    task automatic test_directed_verdicts();
        send_word(kplq_pkg::REQ_LEFT,  48'd0,         1'b0, 1'b0);
        send_word(kplq_pkg::REQ_RIGHT, 48'd0,         1'b0, 1'b1);
        send_word(kplq_pkg::REQ_RIGHT, 48'd150000,    1'b0, 1'b0);
        send_word(kplq_pkg::REQ_LEFT,  48'd200000,    1'b0, 1'b0);
        send_word(kplq_pkg::REQ_LEFT,  48'd300000,    1'b0, 1'b1);
        send_word(kplq_pkg::REQ_LEFT,  48'd350000,    1'b0, 1'b0);
        send_word(kplq_pkg::REQ_RIGHT, 48'd379999,    1'b0, 1'b0);
        send_word(kplq_pkg::REQ_TAKE,  48'd379999,    1'b1, 1'b1);
        send_word(kplq_pkg::REQ_RIGHT, 48'd500000,    1'b1, 1'b0);
        // Timestamps that fall before the last accept times.
        send_word(kplq_pkg::REQ_RIGHT, 48'd100,       1'b0, 1'b0);
        send_word(kplq_pkg::REQ_LEFT,  48'd100,       1'b1, 1'b0);
        // Elapsed times either side of the millisecond cap.
        send_word(kplq_pkg::REQ_RIGHT, 48'd65650000,  1'b0, 1'b0);
        send_word(kplq_pkg::REQ_LEFT,  48'd65834999,  1'b0, 1'b0);
        send_word(kplq_pkg::REQ_RIGHT, 48'd131185000, 1'b0, 1'b0);
        send_word(kplq_pkg::REQ_LEFT,  48'd131370000, 1'b0, 1'b0);
        send_word(kplq_pkg::REQ_RIGHT, STAMP_TOP,     1'b0, 1'b0);
        send_word(kplq_pkg::REQ_LEFT,  STAMP_TOP,     1'b0, 1'b0);
        send_word(kplq_pkg::REQ_TAKE,  STAMP_TOP,     1'b0, 1'b0);
        send_word(kplq_pkg::REQ_CLEAR, STAMP_TOP,     1'b1, 1'b0);
        send_word(kplq_pkg::REQ_TAKE,  STAMP_TOP,     1'b0, 1'b1);
        send_word(kplq_pkg::REQ_RIGHT, STAMP_TOP,     1'b0, 1'b1);
        stamp_us = STAMP_TOP;
    endtask

    task automatic test_spare_register_index();
        write_reg(CFG_SPARE_LO, 32'd0);
        write_reg(CFG_SPARE_HI, WINDOW_MAX);
        stamp_us = '0;
        run_random(40);
    endtask

    task automatic test_zero_windows();
        write_reg(kplq_pkg::CFG_SAME_LOCKOUT, 32'd0);
        write_reg(kplq_pkg::CFG_OPP_LOCKOUT, 32'd0);
        run_random(350);
    endtask

    task automatic test_full_windows();
        write_reg(kplq_pkg::CFG_SAME_LOCKOUT, WINDOW_MAX);
        write_reg(kplq_pkg::CFG_OPP_LOCKOUT, WINDOW_MAX);
        run_random(350);
    endtask

    task automatic test_random_windows();
        logic [63:0] base;
        for (int round = 0; round < 4; round++)
        begin
            write_reg(kplq_pkg::CFG_SAME_LOCKOUT, $urandom_range(1000, 200000));
            write_reg(kplq_pkg::CFG_OPP_LOCKOUT, $urandom_range(1000, 300000));
            base     = {$urandom, $urandom};
            stamp_us = base[TIME_W-1:0];
            run_random(220);
        end
    endtask

    task automatic test_back_to_back();
        write_reg(kplq_pkg::CFG_SAME_LOCKOUT, kplq_pkg::SAME_LOCKOUT_RESET);
        write_reg(kplq_pkg::CFG_OPP_LOCKOUT, kplq_pkg::OPP_LOCKOUT_RESET);
        idling_enabled = 1'b0;
        run_random(400);
    endtask

    initial
    begin
        int unsigned stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idling_enabled && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        knob_word_t w;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    compare_field("pin_is_right", w.pin_is_right, result_ch.pin_is_right);
                    compare_field("left_seen", w.left_seen, result_ch.left_seen);
                    compare_field("right_seen", w.right_seen, result_ch.right_seen);
                    compare_field("verdict", w.verdict, result_ch.verdict);
                    compare_field("since_same_ms", w.since_same_ms, result_ch.since_same_ms);
                    compare_field("since_opposite_ms", w.since_opposite_ms,
                                  result_ch.since_opposite_ms);
                    compare_field("position_total", 32'(w.position_total),
                                  32'(result_ch.position_total));
                    compare_field("pending_delta", 32'(w.pending_delta),
                                  32'(result_ch.pending_delta));
                    compare_field("verdict_count", w.verdict_count, result_ch.verdict_count);
                    words_checked++;
                    if (w.verdict <= kplq_pkg::V_NONE)
                        verdict_tally[w.verdict]++;
                end
            end
        end
    end

    initial
    begin
        int unsigned wait_cycles;
        rst_n                = 1'b0;
        pulse_ch.valid       = 1'b0;
        pulse_ch.req_type    = kplq_pkg::REQ_LEFT;
        pulse_ch.now_us      = '0;
        pulse_ch.left_level  = 1'b0;
        pulse_ch.right_level = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = kplq_pkg::CFG_SAME_LOCKOUT;
        cfg_ch.data          = '0;
        same_window_us       = kplq_pkg::SAME_LOCKOUT_RESET;
        opp_window_us        = kplq_pkg::OPP_LOCKOUT_RESET;
        left_accept_us       = '0;
        right_accept_us      = '0;
        step_delta           = '0;
        step_total           = '0;
        foreach (verdict_counts[i])
            verdict_counts[i] = '0;
        foreach (verdict_tally[i])
            verdict_tally[i] = 0;
        stamp_us       = '0;
        idling_enabled = 1'b1;
        mismatches     = 0;
        words_sent     = 0;
        words_checked  = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_verdicts();
        test_spare_register_index();
        test_zero_windows();
        test_full_windows();
        test_random_windows();
        test_back_to_back();

        pulse_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (expected_words.size() != 0 && wait_cycles < 1000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (4) @(negedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d result words never arrived", expected_words.size());
            mismatches++;
        end

        $display("Checked %0d of %0d words: cw %0d, ccw %0d, bounce %0d, cross-talk %0d,",
                 words_checked, words_sent, verdict_tally[kplq_pkg::V_CW],
                 verdict_tally[kplq_pkg::V_CCW], verdict_tally[kplq_pkg::V_SAME],
                 verdict_tally[kplq_pkg::V_OPP]);
        $display("glitch %0d, take or clear %0d, over default, zero, full and random windows.",
                 verdict_tally[kplq_pkg::V_GLITCH], verdict_tally[kplq_pkg::V_NONE]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
